>>> hw/rtl/sib_pkg.sv
// Shared types, codes and widths for the sector interval block table.
`default_nettype none

package sib_pkg;

  // Field widths
  localparam int SECTOR_BITS   = 16;
  localparam int COUNT_BITS    = 8;
  localparam int REF_BITS      = 8;
  localparam int SLOT_BITS     = 4;
  localparam int STATUS_BITS   = 3;
  localparam int TYPE_BITS     = 2;
  localparam int UPD_BITS      = 2;
  localparam int TABLE_ENTRIES = 16;

  typedef logic [SECTOR_BITS-1:0] sector_t;
  typedef logic [SECTOR_BITS:0]   sector_ext_t;   // one spare bit for run ends
  typedef logic [COUNT_BITS-1:0]  count_t;
  typedef logic [REF_BITS-1:0]    refs_t;
  typedef logic [SLOT_BITS-1:0]   slot_t;
  typedef logic [STATUS_BITS-1:0] status_t;
  typedef logic [TYPE_BITS-1:0]   req_type_t;
  typedef logic [UPD_BITS-1:0]    upd_op_t;

  // Request types
  localparam req_type_t REQ_GET    = 2'd0;
  localparam req_type_t REQ_PUT    = 2'd1;
  localparam req_type_t REQ_RESIZE = 2'd2;

  // Status codes
  localparam status_t ST_HIT         = 3'd0;
  localparam status_t ST_INSERTED    = 3'd1;
  localparam status_t ST_WRONG_COUNT = 3'd2;
  localparam status_t ST_OVERLAP     = 3'd3;
  localparam status_t ST_ZERO_SIZE   = 3'd4;
  localparam status_t ST_NOT_FOUND   = 3'd5;
  localparam status_t ST_FULL        = 3'd6;

  // Table update operations broadcast to the cells
  localparam upd_op_t UPD_NONE = 2'd0;
  localparam upd_op_t UPD_REFS = 2'd1;
  localparam upd_op_t UPD_LEN  = 2'd2;
  localparam upd_op_t UPD_INS  = 2'd3;

  typedef struct packed {
    req_type_t req_type;
    sector_t   start_sector;
    count_t    sector_count;
  } req_t;

  typedef struct packed {
    status_t status;
    slot_t   slot;
    refs_t   ref_count;
    logic    fill_valid;
    sector_t fill_start;
    count_t  fill_count;
  } rsp_t;

  // Contents of one table entry
  typedef struct packed {
    logic    valid;
    sector_t start;
    count_t  len;
    refs_t   refs;
  } ent_t;

  // What the marked cell reports back; zero from every other cell
  typedef struct packed {
    logic   found;
    logic   eq;
    logic   below;
    logic   over;
    count_t len;
    refs_t  refs;
  } mrk_t;

  // Update applied to the marked cell (and the shift behind it)
  typedef struct packed {
    upd_op_t op;
    sector_t start;
    count_t  count;
    refs_t   refs;
  } upd_t;

endpackage

`default_nettype wire

>>> hw/rtl/sib_cell.sv
// One table entry: compare against the request, mark, update and shift.
`default_nettype none

module sib_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cap,
  input  wire sib_pkg::req_t req,
  input  wire sib_pkg::ent_t prev_ent,
  input  wire sib_pkg::ent_t next_ent,
  input  wire logic          seen_in,
  input  wire logic          apply,
  input  wire sib_pkg::upd_t upd,
  output sib_pkg::ent_t      ent,
  output sib_pkg::mrk_t      mrk,
  output logic               seen_out
);

  logic             valid;
  sib_pkg::sector_t start;
  sib_pkg::count_t  len;
  sib_pkg::refs_t   refs;

  logic f_eq, f_stop, f_below, f_over;

  sib_pkg::sector_ext_t ent_end, req_end;
  logic eq, past, below, over, stop;
  logic sel, first_free, mark;

  assign ent = '{valid: valid, start: start, len: len, refs: refs};

  // Compare this entry with the incoming request word
  always_comb begin
    ent_end = sib_pkg::sector_ext_t'(start) + sib_pkg::sector_ext_t'(len);
    req_end = sib_pkg::sector_ext_t'(req.start_sector)
            + sib_pkg::sector_ext_t'(req.sector_count);
    eq      = (start == req.start_sector);
    past    = (sib_pkg::sector_ext_t'(req.start_sector) >= ent_end);
    below   = (req_end <= sib_pkg::sector_ext_t'(start));
    over    = next_ent.valid && (req_end > sib_pkg::sector_ext_t'(next_ent.start));
    // a get stops at a shared start or at the first run it does not pass
    stop    = valid && (eq || ((req.req_type == sib_pkg::REQ_GET) && !past));
  end

  // Compare flags, held for the decision cycle
  always_ff @(posedge clk) begin
    if (cap) begin
      f_eq    <= eq;
      f_stop  <= stop;
      f_below <= below;
      f_over  <= over;
    end
  end

  // First stopping entry, or the first free slot when nothing stopped
  always_comb begin
    sel        = f_stop && !seen_in;
    first_free = !valid && prev_ent.valid && !seen_in;
    mark       = sel || first_free;
    seen_out   = seen_in || mark;
    mrk        = '0;
    if (mark) begin
      mrk = '{found: sel, eq: f_eq, below: f_below, over: f_over,
              len: len, refs: refs};
    end
  end

  // Valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (apply && (upd.op == sib_pkg::UPD_INS)) begin
      if (mark) begin
        valid <= 1'b1;
      end else if (seen_in) begin
        valid <= prev_ent.valid;
      end
    end
  end

  // Entry payload
  always_ff @(posedge clk) begin
    if (apply) begin
      case (upd.op)
        sib_pkg::UPD_REFS: begin
          if (mark) refs <= upd.refs;
        end
        sib_pkg::UPD_LEN: begin
          if (mark) len <= upd.count;
        end
        sib_pkg::UPD_INS: begin
          if (mark) begin
            start <= upd.start;
            len   <= upd.count;
            refs  <= upd.refs;
          end else if (seen_in) begin
            start <= prev_ent.start;
            len   <= prev_ent.len;
            refs  <= prev_ent.refs;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/sector_interval_block_table.sv
// Top level: request decode, row of entry cells, result register.
//
//  channel | valid     | stall     | word
//  --------+-----------+-----------+------------------------------------------
//  request | req_valid | req_stall | req (req_type, start_sector, sector_count)
//  result  | rsp_valid | rsp_stall | rsp (status, slot, ref_count, fill_*)
//
//  Each request is accepted on an edge that registers every cell's compare
//  flags; the decision cycle then resolves the first marked cell along the
//  row, updates the table and loads the result register.
//  The decision cycle waits while a previous result is still stalled.
//  A new request can be taken in the cycle after the previous one is resolved.
//  Reset clears all entry valid bits at once; no clearing pass is needed.
`default_nettype none

module sector_interval_block_table #(
  parameter int TABLE_ENTRIES = sib_pkg::TABLE_ENTRIES
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire sib_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output sib_pkg::rsp_t      rsp
);

  localparam int IdxW = $clog2(TABLE_ENTRIES);
  typedef logic [IdxW-1:0] idx_t;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_BUSY = 1'b1;

  logic          state;
  sib_pkg::req_t rq;
  logic          accept, go;

  sib_pkg::ent_t ents  [TABLE_ENTRIES];
  sib_pkg::mrk_t mrks  [TABLE_ENTRIES];
  logic [TABLE_ENTRIES:0]   seen;
  logic [TABLE_ENTRIES-1:0] vld;

  sib_pkg::mrk_t m;
  idx_t          idx;
  logic          full;
  sib_pkg::upd_t upd;
  sib_pkg::rsp_t rsp_next;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign go        = (state == S_BUSY) && (!rsp_valid || !rsp_stall);
  assign seen[0]   = 1'b0;
  assign full      = vld[TABLE_ENTRIES-1];

  // Row of entry cells, each linked to its neighbors
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    sib_pkg::ent_t prev_ent, next_ent;

    // the row's head sees an occupied neighbor, its tail an empty one
    if (i == 0) begin : g_head
      assign prev_ent = '{valid: 1'b1, start: '0, len: '0, refs: '0};
    end else begin : g_body
      assign prev_ent = ents[i-1];
    end
    if (i == TABLE_ENTRIES - 1) begin : g_tail
      assign next_ent = '0;
    end else begin : g_next
      assign next_ent = ents[i+1];
    end

    sib_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cap      (accept),
      .req      (req),
      .prev_ent (prev_ent),
      .next_ent (next_ent),
      .seen_in  (seen[i]),
      .apply    (go),
      .upd      (upd),
      .ent      (ents[i]),
      .mrk      (mrks[i]),
      .seen_out (seen[i+1])
    );

    assign vld[i] = ents[i].valid;
  end

  // Collect the marked cell's report and position
  always_comb begin
    m   = '0;
    idx = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      m = sib_pkg::mrk_t'(m | mrks[i]);
      if (seen[i+1] && !seen[i]) idx = idx | idx_t'(i);
    end
  end

  // Decide the status and the table update
  always_comb begin
    rsp_next = '{status: sib_pkg::ST_NOT_FOUND, slot: '0, ref_count: '0,
                 fill_valid: 1'b0, fill_start: '0, fill_count: '0};
    upd      = '{op: sib_pkg::UPD_NONE, start: rq.start_sector,
                 count: rq.sector_count, refs: '0};
    case (rq.req_type)
      sib_pkg::REQ_GET: begin
        if (m.found && m.eq) begin
          rsp_next.slot = sib_pkg::slot_t'(idx);
          if (m.len == rq.sector_count) begin
            upd.op   = sib_pkg::UPD_REFS;
            upd.refs = (m.refs == '1) ? m.refs : sib_pkg::refs_t'(m.refs + 1'b1);
            rsp_next.status    = sib_pkg::ST_HIT;
            rsp_next.ref_count = upd.refs;
          end else begin
            rsp_next.status    = sib_pkg::ST_WRONG_COUNT;
            rsp_next.ref_count = m.refs;
          end
        end else if (m.found && !m.below) begin
          rsp_next.status    = sib_pkg::ST_OVERLAP;
          rsp_next.slot      = sib_pkg::slot_t'(idx);
          rsp_next.ref_count = m.refs;
        end else if (full) begin
          rsp_next.status = sib_pkg::ST_FULL;
        end else begin
          // insert at the marked position, the rest shifts down one cell
          upd.op   = sib_pkg::UPD_INS;
          upd.refs = sib_pkg::refs_t'(1);
          rsp_next.status     = sib_pkg::ST_INSERTED;
          rsp_next.slot       = sib_pkg::slot_t'(idx);
          rsp_next.ref_count  = upd.refs;
          rsp_next.fill_valid = (rq.sector_count != '0);
          rsp_next.fill_start = (rq.sector_count != '0) ? rq.start_sector : '0;
          rsp_next.fill_count = rq.sector_count;
        end
      end
      sib_pkg::REQ_PUT: begin
        if (m.found) begin
          upd.op   = sib_pkg::UPD_REFS;
          upd.refs = (m.refs == '0) ? m.refs : sib_pkg::refs_t'(m.refs - 1'b1);
          rsp_next.status    = sib_pkg::ST_HIT;
          rsp_next.slot      = sib_pkg::slot_t'(idx);
          rsp_next.ref_count = upd.refs;
        end
      end
      sib_pkg::REQ_RESIZE: begin
        if (rq.sector_count == '0) begin
          rsp_next.status = sib_pkg::ST_ZERO_SIZE;
        end else if (m.found) begin
          rsp_next.slot      = sib_pkg::slot_t'(idx);
          rsp_next.ref_count = m.refs;
          if (m.over) begin
            rsp_next.status = sib_pkg::ST_OVERLAP;
          end else begin
            upd.op          = sib_pkg::UPD_LEN;
            rsp_next.status = sib_pkg::ST_HIT;
            // growing reads in the sectors past the old end
            if (rq.sector_count > m.len) begin
              rsp_next.fill_valid = 1'b1;
              rsp_next.fill_start = sib_pkg::sector_t'(rq.start_sector
                                    + sib_pkg::sector_t'(m.len));
              rsp_next.fill_count = sib_pkg::count_t'(rq.sector_count - m.len);
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control: idle / decide
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else if (accept) begin
      state <= S_BUSY;
    end else if (go) begin
      state <= S_IDLE;
    end
  end

  // Request word held for the decision cycle
  always_ff @(posedge clk) begin
    if (accept) rq <= req;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (go) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) rsp <= rsp_next;
  end

`ifndef SYNTHESIS
  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    (vld[TABLE_ENTRIES-1:1] & ~vld[TABLE_ENTRIES-2:0]) == '0)
    else $error("valid entries do not form a prefix");

  a_ins_has_mark: assert property (@(posedge clk) disable iff (rst)
    go && (upd.op == sib_pkg::UPD_INS) |-> seen[TABLE_ENTRIES])
    else $error("insert without a marked cell");

  a_ins_grows: assert property (@(posedge clk) disable iff (rst)
    go && (upd.op == sib_pkg::UPD_INS) |=> $countones(vld) == $past($countones(vld)) + 1)
    else $error("insert did not add exactly one entry");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_BUSY))
    else $error("accepted request not held for decision");
`endif

endmodule

`default_nettype wire

>>> dv/sector_interval_block_table_tb.sv
// Self-checking testbench for the sector interval block table.
module sector_interval_block_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sib_pkg::*;

  // The two-bit request type has one spare encoding, which the block answers as not found
  localparam req_type_t REQ_UNUSED = 2'd3;

  logic  clk;
  logic  rst       = 1'b1;
  logic  req_valid = 1'b0;
  logic  req_stall;
  req_t  req       = '0;
  logic  rsp_valid;
  logic  rsp_stall = 1'b0;
  rsp_t  rsp;

  sector_interval_block_table u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // Shadow copy of the run table; valid entries always form a prefix
  sector_t tbl_start [TABLE_ENTRIES];
  count_t  tbl_len   [TABLE_ENTRIES];
  refs_t   tbl_refs  [TABLE_ENTRIES];
  int      tbl_used = 0;

  rsp_t    pending_rsp[$];
  int      n_sent     = 0;
  int      n_checked  = 0;
  int      n_errors   = 0;
  int      status_seen[8];
  bit      no_idle    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the handshakes hang
  initial begin
    #20_000_000;
    $display("[sector_interval_block_table] ERROR");
    $finish;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int gap_len();
    int p;
    if (no_idle) return 0;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // First valid slot whose run starts at s, or -1
  function automatic int find_run(sector_t s);
    int i;
    for (i = 0; i < tbl_used; i++)
      if (tbl_start[i] == s) return i;
    return -1;
  endfunction

  // Applies one request to the shadow table and returns the response it must give
  function automatic rsp_t apply_request(req_t w);
    rsp_t o;
    int   i, k, s, c, prev;
    o = '0;
    s = w.start_sector;
    c = w.sector_count;
    case (w.req_type)
      REQ_GET: begin
        for (i = 0; i < tbl_used; i++) begin
          if (tbl_start[i] == w.start_sector) begin
            o.slot = slot_t'(i);
            if (tbl_len[i] != w.sector_count) begin
              o.status    = ST_WRONG_COUNT;
              o.ref_count = tbl_refs[i];
              return o;
            end
            if (tbl_refs[i] != '1) tbl_refs[i]++;
            o.status    = ST_HIT;
            o.ref_count = tbl_refs[i];
            return o;
          end
          // run ends are compared without wrapping
          if (s >= int'(tbl_start[i]) + int'(tbl_len[i])) continue;
          if (s + c <= int'(tbl_start[i])) break;
          o.status    = ST_OVERLAP;
          o.slot      = slot_t'(i);
          o.ref_count = tbl_refs[i];
          return o;
        end
        if (tbl_used >= TABLE_ENTRIES) begin
          o.status = ST_FULL;
          return o;
        end
        // open a hole at i and shift the tail up
        for (k = tbl_used; k > i; k--) begin
          tbl_start[k] = tbl_start[k-1];
          tbl_len[k]   = tbl_len[k-1];
          tbl_refs[k]  = tbl_refs[k-1];
        end
        tbl_start[i] = w.start_sector;
        tbl_len[i]   = w.sector_count;
        tbl_refs[i]  = refs_t'(1);
        tbl_used++;
        o.status    = ST_INSERTED;
        o.slot      = slot_t'(i);
        o.ref_count = refs_t'(1);
        if (c != 0) begin
          o.fill_valid = 1'b1;
          o.fill_start = w.start_sector;
          o.fill_count = w.sector_count;
        end
      end
      REQ_PUT: begin
        k = find_run(w.start_sector);
        if (k < 0) begin
          o.status = ST_NOT_FOUND;
          return o;
        end
        if (tbl_refs[k] != '0) tbl_refs[k]--;
        o.status    = ST_HIT;
        o.slot      = slot_t'(k);
        o.ref_count = tbl_refs[k];
      end
      REQ_RESIZE: begin
        if (c == 0) begin
          o.status = ST_ZERO_SIZE;
          return o;
        end
        k = find_run(w.start_sector);
        if (k < 0) begin
          o.status = ST_NOT_FOUND;
          return o;
        end
        o.slot      = slot_t'(k);
        o.ref_count = tbl_refs[k];
        if (k + 1 < tbl_used && s + c > int'(tbl_start[k+1])) begin
          o.status = ST_OVERLAP;
          return o;
        end
        prev       = tbl_len[k];
        tbl_len[k] = w.sector_count;
        o.status   = ST_HIT;
        // growing reads in only the added tail
        if (c > prev) begin
          o.fill_valid = 1'b1;
          o.fill_start = sector_t'(s + prev);
          o.fill_count = count_t'(c - prev);
        end
      end
      default: o.status = ST_NOT_FOUND;
    endcase
    return o;
  endfunction

  // Sends one request word and records the response it must produce
  task automatic send_word(input req_type_t t, input sector_t s, input count_t c);
    int   gap;
    req_t w;
    w.req_type     = t;
    w.start_sector = s;
    w.sector_count = c;
    gap = gap_len();
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= w;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall !== 1'b0) @(posedge clk);
    pending_rsp.push_back(apply_request(w));
    n_sent++;
  endtask

  // Holds off the request side until every response is back
  task automatic wait_for_results();
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // Response side: random stall, then compare each accepted word
  int   stall_left = 0;
  rsp_t want;
  logic bad;

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
        if (pending_rsp.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("%0t: response with none pending: st=%0d slot=%0d refs=%0d",
                     $realtime, rsp.status, rsp.slot, rsp.ref_count);
        end else begin
          want = pending_rsp.pop_front();
          n_checked++;
          status_seen[rsp.status]++;
          bad = (rsp.status !== want.status) || (rsp.slot !== want.slot) ||
                (rsp.ref_count !== want.ref_count) ||
                (rsp.fill_valid !== want.fill_valid) ||
                (rsp.fill_start !== want.fill_start) ||
                (rsp.fill_count !== want.fill_count);
          if (bad) begin
            n_errors++;
            if (n_errors <= 10) begin
              $display("%0t: response %0d mismatch", $realtime, n_checked);
              $display("  expected st=%0d slot=%0d refs=%0d fill=%b start=%h count=%0d",
                       want.status, want.slot, want.ref_count, want.fill_valid,
                       want.fill_start, want.fill_count);
              $display("  actual   st=%0d slot=%0d refs=%0d fill=%b start=%h count=%0d",
                       rsp.status, rsp.slot, rsp.ref_count, rsp.fill_valid,
                       rsp.fill_start, rsp.fill_count);
            end
          end
        end
      end
      if (stall_left > 0)
        stall_left--;
      else if (!no_idle && $urandom_range(0, 2) == 0)
        stall_left = gap_len();
      rsp_stall <= (stall_left > 0);
    end
  end

  // Requests against an empty table, and the spare request type
  task automatic test_empty_table();
    send_word(REQ_UNUSED, 16'hFFFF, 8'd255);
    send_word(REQ_PUT,    16'h1234, 8'd0);
    send_word(REQ_RESIZE, 16'h1234, 8'd0);
    send_word(REQ_RESIZE, 16'h1234, 8'd9);
  endtask

  // Insert, hit, wrong count and overlap, including zero-length runs
  task automatic test_get_paths();
    send_word(REQ_GET, 16'h8000, 8'd0);     // zero-length insert, no fill
    send_word(REQ_GET, 16'h8000, 8'd0);     // hit on it
    send_word(REQ_GET, 16'h0000, 8'd255);   // lowest start, largest count
    send_word(REQ_GET, 16'h0000, 8'd255);
    send_word(REQ_GET, 16'h0000, 8'd7);     // same start, other count
    send_word(REQ_GET, 16'h0010, 8'd255);   // overlap with equal count
    send_word(REQ_GET, 16'h0010, 8'd3);
    send_word(REQ_GET, 16'h7FFF, 8'd2);     // straddles the empty run
    send_word(REQ_GET, 16'hFFFF, 8'd1);     // highest start
  endtask

  // Grow with fill (incl. wrap of fill start), shrink, and overlap with next
  task automatic test_resize_paths();
    send_word(REQ_RESIZE, 16'hFFFF, 8'd200);
    send_word(REQ_RESIZE, 16'hFFFF, 8'd5);
    send_word(REQ_RESIZE, 16'h0000, 8'd255);  // same size
    send_word(REQ_GET,    16'h0100, 8'd16);
    send_word(REQ_GET,    16'h0180, 8'd4);
    send_word(REQ_RESIZE, 16'h0100, 8'd129);  // one past the next start
    send_word(REQ_RESIZE, 16'h0100, 8'd128);  // exactly abuts
  endtask

  // Release down to zero and past it
  task automatic test_put_paths();
    send_word(REQ_PUT, 16'h0180, 8'd0);
    send_word(REQ_PUT, 16'h0180, 8'hFF);
    send_word(REQ_PUT, 16'h8000, 8'd0);
    send_word(REQ_GET, 16'h0180, 8'd4);
  endtask

  // Drive one reference count into saturation and back down to zero, where it holds
  task automatic test_ref_saturation();
    int n;
    for (n = 0; n < 260; n++) begin
      no_idle = (n < 130);
      send_word(REQ_GET, 16'h0180, 8'd4);
    end
    no_idle = 1'b0;
    wait_for_results();
    for (n = 0; n < 260; n++)
      send_word(REQ_PUT, 16'h0180, count_t'($urandom()));
  endtask

  // Mostly requests aimed at existing runs, plus fresh gets and raw noise
  task automatic test_random_traffic(input int count);
    int        n, e, p;
    req_type_t t;
    sector_t   s;
    count_t    c;
    for (n = 0; n < count; n++) begin
      no_idle = ((n / 100) % 4) == 2;
      if (n == count / 2) wait_for_results();
      p = $urandom_range(0, 99);
      if (tbl_used != 0 && p < 55) begin
        e = $urandom_range(0, tbl_used - 1);
        s = tbl_start[e];
        c = tbl_len[e];
        case ($urandom_range(0, 5))
          0, 1: t = REQ_GET;
          2: begin
            t = REQ_GET;
            c = count_t'($urandom_range(0, 255));
          end
          3: begin
            t = REQ_PUT;
            c = count_t'($urandom_range(0, 255));
          end
          4: begin
            t = REQ_RESIZE;
            if ($urandom_range(0, 1) != 0)
              c = count_t'($urandom_range(0, 255));
            else
              c = c + count_t'($urandom_range(0, 6));
          end
          default: begin
            // start just past the run's first sector
            t = REQ_GET;
            s = s + sector_t'($urandom_range(1, 8));
            c = count_t'($urandom_range(0, 40));
          end
        endcase
      end else if (p < 85) begin
        t = REQ_GET;
        if ($urandom_range(0, 1) != 0)
          s = sector_t'($urandom_range(0, 16'h0FFF));
        else
          s = sector_t'($urandom());
        if ($urandom_range(0, 3) == 0)
          c = count_t'($urandom_range(0, 255));
        else
          c = count_t'($urandom_range(0, 32));
      end else begin
        t = req_type_t'($urandom_range(0, 3));
        s = sector_t'($urandom());
        c = count_t'($urandom());
      end
      send_word(t, s, c);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_get_paths();
    test_resize_paths();
    test_put_paths();
    wait_for_results();
    test_ref_saturation();
    wait_for_results();
    test_random_traffic(1300);
    wait_for_results();
    repeat (10) @(posedge clk);
    $display("Sent %0d requests, checked %0d responses; %0d of %0d table slots in use.",
             n_sent, n_checked, tbl_used, TABLE_ENTRIES);
    $display("Statuses: hit %0d ins %0d wrong %0d ovl %0d zero %0d nf %0d full %0d",
             status_seen[ST_HIT], status_seen[ST_INSERTED], status_seen[ST_WRONG_COUNT],
             status_seen[ST_OVERLAP], status_seen[ST_ZERO_SIZE],
             status_seen[ST_NOT_FOUND], status_seen[ST_FULL]);
    if (n_errors == 0 && pending_rsp.size() == 0)
      $display("[sector_interval_block_table] OK");
    else
      $display("[sector_interval_block_table] ERROR");
    $finish;
  end

endmodule
